### hw/rtl/dynarr_pkg.sv
// Shared types and constants for the dynamic array insert/erase engine.
`timescale 1ns / 1ps

package dynarr_pkg;

	localparam int DEPTH       = 1024;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int CAP_W       = CNT_W + 1;
	localparam int POS_W       = 11;
	localparam int WORD_W      = 32;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_ERASE  = 2'd1,
		CMD_GET    = 2'd2,
		CMD_SET    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                     command;
		logic [POS_W-1:0]         position;
		logic [POS_W-1:0]         erase_count;
		logic signed [WORD_W-1:0] value;
		logic                     last_in_run;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic [POS_W-1:0]         element_count;
		logic [POS_W:0]           capacity_now;
		status_t                  status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic check;
		logic shift;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_shift;
		logic shift_last;
		logic out_free;
	} dp_stat_t;

endpackage

### hw/rtl/dynamic_array_insert_erase_engine.sv
// Top level of the dynamic array insert/erase engine.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------
//  request | req_valid | req_stall | req_data (req_t)
//  result  | rsp_valid | rsp_stall | rsp_data (rsp_t)
//
// A request with nothing to move steps through accept, check and finish. An
// insert or erase that moves words adds shift steps for them and then a drain step.
// The worst case moves DEPTH - 1 words. The element memory takes one read and
// one write per cycle.
// Reset clears count, capacity (to 1) and run offset; memory is not cleared.
// A stalled result holds the finish step until the output register frees.
`timescale 1ns / 1ps

module dynamic_array_insert_erase_engine import dynarr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	dynarr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.stat      (stat),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	dynarr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_data  (req_data),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

	// one request at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while busy");

	a_cap_above_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((POS_W + 1)'(rsp_data.element_count) < rsp_data.capacity_now &&
		               rsp_data.element_count <= POS_W'(DEPTH)))
		else $error("count or capacity out of range");

	a_err_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.read_value == '0))
		else $error("failed request returned data");

endmodule

### hw/rtl/dynarr_dp.sv
// Datapath: element memory, count/capacity/run offset and the result register.
`timescale 1ns / 1ps

module dynarr_dp import dynarr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	input  req_t     req_data,
	input  logic     rsp_stall,
	output dp_stat_t stat,
	output logic     rsp_valid,
	output rsp_t     rsp_data
);

	logic signed [VALUE_WIDTH-1:0] mem [DEPTH];

	req_t                          req_q;
	logic [CNT_W-1:0]              count_q;
	logic [CAP_W-1:0]              cap_q;
	logic [CNT_W-1:0]              offset_q;
	status_t                       status_q;
	logic [ADDR_W-1:0]             ptr_q;
	logic                          wr_v_s1;
	logic [ADDR_W-1:0]             wr_addr_s1;
	logic signed [VALUE_WIDTH-1:0] rdata_q;
	logic                          rsp_valid_q;
	rsp_t                          rsp_q;

	logic [CAP_W-1:0]              at;
	logic [CAP_W-1:0]              erase_end;
	logic [CAP_W-1:0]              count_w;
	logic                          is_ins;
	status_t                       code;
	logic                          need_shift;
	logic [ADDR_W-1:0]             rd_addr_shift;
	logic                          shift_last;
	logic [CNT_W-1:0]              count_inc;
	logic [CNT_W-1:0]              count_nx;
	logic [CAP_W-1:0]              cap_nx;
	logic [CNT_W-1:0]              offset_nx;
	logic                          mem_re;
	logic [ADDR_W-1:0]             mem_raddr;
	logic                          mem_we;
	logic [ADDR_W-1:0]             mem_waddr;
	logic signed [VALUE_WIDTH-1:0] mem_wdata;

	assign at        = CAP_W'(req_q.position) + CAP_W'(offset_q);
	assign erase_end = CAP_W'(req_q.position) + CAP_W'(req_q.erase_count);
	assign count_w   = CAP_W'(count_q);
	assign is_ins    = (req_q.command == CMD_INSERT);

	always_comb begin
		code       = ST_OK;
		need_shift = 1'b0;
		unique case (req_q.command)
			CMD_INSERT: begin
				if (at > count_w) begin
					code = ST_RANGE;
				end else if (count_q == CNT_W'(DEPTH)) begin
					code = ST_FULL;
				end else begin
					need_shift = (at < count_w);
				end
			end
			CMD_ERASE: begin
				if (erase_end > count_w) begin
					code = ST_RANGE;
				end else begin
					need_shift = (req_q.erase_count != '0) && (erase_end < count_w);
				end
			end
			CMD_GET, CMD_SET: begin
				if (CNT_W'(req_q.position) >= count_q) begin
					code = ST_RANGE;
				end
			end
		endcase
	end

	// insert walks the tail downward, erase walks upward from the hole
	assign rd_addr_shift = is_ins ? ptr_q : ptr_q + ADDR_W'(req_q.erase_count);
	assign shift_last    = is_ins ? (CAP_W'(ptr_q) == at)
	                              : (CNT_W'(rd_addr_shift) + CNT_W'(1) == count_q);

	assign stat.need_shift = need_shift;
	assign stat.shift_last = shift_last;
	assign stat.out_free   = !rsp_valid_q || !rsp_stall;

	assign count_inc = count_q + CNT_W'(1);

	always_comb begin
		count_nx  = count_q;
		cap_nx    = cap_q;
		offset_nx = offset_q;
		if (status_q == ST_OK) begin
			if (is_ins) begin
				count_nx  = count_inc;
				cap_nx    = (CAP_W'(count_inc) == cap_q) ? {cap_q[CAP_W-2:0], 1'b0} : cap_q;
				offset_nx = offset_q + CNT_W'(1);
			end else if (req_q.command == CMD_ERASE) begin
				count_nx = count_q - CNT_W'(req_q.erase_count);
			end
		end
		if (is_ins && req_q.last_in_run) begin
			offset_nx = '0;
		end
	end

	// memory ports
	assign mem_re    = cmd.shift || (cmd.check && req_q.command == CMD_GET);
	assign mem_raddr = cmd.shift ? rd_addr_shift : req_q.position[ADDR_W-1:0];

	always_comb begin
		if (wr_v_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wr_addr_s1;
			mem_wdata = rdata_q;
		end else begin
			mem_we    = cmd.finish && (status_q == ST_OK) &&
			            (is_ins || req_q.command == CMD_SET);
			mem_waddr = is_ins ? at[ADDR_W-1:0] : req_q.position[ADDR_W-1:0];
			mem_wdata = VALUE_WIDTH'(req_q.value);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_data;
		end
		if (cmd.check) begin
			status_q <= code;
			ptr_q    <= is_ins ? ADDR_W'(count_q - CNT_W'(1)) : req_q.position[ADDR_W-1:0];
		end else if (cmd.shift) begin
			ptr_q <= is_ins ? ptr_q - ADDR_W'(1) : ptr_q + ADDR_W'(1);
		end
		if (cmd.shift) begin
			wr_addr_s1 <= is_ins ? rd_addr_shift + ADDR_W'(1) : ptr_q;
		end
		if (cmd.finish) begin
			rsp_q.read_value    <= (req_q.command == CMD_GET && status_q == ST_OK)
			                       ? WORD_W'(rdata_q) : '0;
			rsp_q.element_count <= POS_W'(count_nx);
			rsp_q.capacity_now  <= (POS_W + 1)'(cap_nx);
			rsp_q.status        <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CAP_W'(1);
			offset_q    <= '0;
			wr_v_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			wr_v_s1 <= cmd.shift;
			if (cmd.finish) begin
				count_q     <= count_nx;
				cap_q       <= cap_nx;
				offset_q    <= offset_nx;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

### hw/rtl/dynarr_ctrl.sv
// Controller state machine: sequences check, shift, drain and finish per request.
`timescale 1ns / 1ps

module dynarr_ctrl import dynarr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  dp_stat_t stat,
	output logic     req_stall,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CHECK  = 5'b00010,
		S_SHIFT  = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = req_valid;
				if (req_valid) begin
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_nx  = stat.need_shift ? S_SHIFT : S_FINISH;
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (stat.shift_last) begin
					state_nx = S_DRAIN;
				end
			end
			// let the last moved word land before the final write
			S_DRAIN: begin
				state_nx = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = stat.out_free;
				if (stat.out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule
